// File: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the bias calibrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/sabc_pkg.sv
// Types, constants and codes of the six-axis bias calibrator.
`default_nettype none

package sabc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CH_N = 6;
  localparam int OFF_W = 26;
  localparam int STATUS_W = 3;
  localparam int COUNT_CFG_W = 13;
  localparam int ONE_G_W = 15;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int MAX_CALIB_SAMPLES_DEF = 4096;
  localparam int OFFSET_FRAC_BITS_DEF = 8;

  localparam logic [COUNT_CFG_W-1:0] CALIB_COUNT_RST = COUNT_CFG_W'(200);
  localparam logic [ONE_G_W-1:0] ONE_G_RST = ONE_G_W'(16384);

  localparam int ACCEL_Z_IDX = 2;
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
  localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

  localparam logic CMD_CALIB = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_CORRECTED   = 3'd0,
    STAT_RAW         = 3'd1,
    STAT_READ_FAIL   = 3'd2,
    STAT_CAL_ACCEPT  = 3'd3,
    STAT_CAL_DONE    = 3'd4,
    STAT_CAL_FAIL    = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_CALIB_SAMPLE_COUNT = 1'b0,
    REG_ACCEL_ONE_G        = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DECIDE,
    ST_MUL,
    ST_NUM,
    ST_START,
    ST_WAIT,
    ST_CORR,
    ST_CFIX,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX
  } div_state_t;

  typedef struct packed {
    logic                       command;
    logic                       read_ok;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } sample_t;

  typedef struct packed {
    status_t                    status;
    logic signed [SAMPLE_W-1:0] out_accel_x;
    logic signed [SAMPLE_W-1:0] out_accel_y;
    logic signed [SAMPLE_W-1:0] out_accel_z;
    logic signed [SAMPLE_W-1:0] out_gyro_x;
    logic signed [SAMPLE_W-1:0] out_gyro_y;
    logic signed [SAMPLE_W-1:0] out_gyro_z;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/sabc_div.sv
// Serial restoring divider for the offsets: signed numerator, unsigned count, saturated quotient.
`default_nettype none

module sabc_div #(
  parameter int NUM_W = 30,
  parameter int CNT_W = 13,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [NUM_W-1:0]          num,
  input  wire logic [CNT_W-1:0]                 den,
  output logic                                  done,
  output logic signed [sabc_pkg::OFF_W-1:0]     quo
);

  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int OFF_W = sabc_pkg::OFF_W;

  sabc_pkg::div_state_t state, state_next;

  logic [DVD_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den_r;
  logic [OFF_W-1:0]  qmag;
  logic              sticky;
  logic              neg;
  logic [DCNT_W-1:0] cnt;

  logic [NUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic              over_pos;
  logic              over_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sabc_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sabc_pkg::DIV_IDLE: begin
        if (start) begin
          state_next = sabc_pkg::DIV_RUN;
        end
      end
      sabc_pkg::DIV_RUN: begin
        if (cnt == DCNT_W'(DVD_W - 1)) begin
          state_next = sabc_pkg::DIV_FIX;
        end
      end
      sabc_pkg::DIV_FIX: begin
        state_next = sabc_pkg::DIV_IDLE;
      end
      default: begin
        state_next = sabc_pkg::DIV_IDLE;
      end
    endcase
  end

  always_comb begin
    mag   = num[NUM_W-1] ? -num : num;
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  // one quotient bit per cycle, dividend is |num| with FRAC_BITS zeros appended
  always_ff @(posedge clk) begin
    case (state)
      sabc_pkg::DIV_IDLE: begin
        if (start) begin
          dvd    <= DVD_W'(mag) << FRAC_BITS;
          rem    <= '0;
          den_r  <= den;
          qmag   <= '0;
          sticky <= 1'b0;
          neg    <= num[NUM_W-1];
          cnt    <= '0;
        end
      end
      sabc_pkg::DIV_RUN: begin
        dvd    <= dvd << 1;
        rem    <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        qmag   <= {qmag[OFF_W-2:0], ge};
        sticky <= sticky | qmag[OFF_W-1];
        cnt    <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    over_pos = sticky | qmag[OFF_W-1];
    over_neg = sticky | (qmag > {1'b1, {(OFF_W-1){1'b0}}});
    if (neg) begin
      quo = over_neg ? sabc_pkg::OFF_MIN : $signed(-qmag);
    end else begin
      quo = over_pos ? sabc_pkg::OFF_MAX : $signed(qmag);
    end
    done = (state == sabc_pkg::DIV_FIX);
  end

endmodule

`default_nettype wire

// File: rtl/six_axis_bias_calibrator.sv
// Six-axis bias calibrator: run accumulation, offset division and bit-serial correction.
//
// Each accepted word is one sensor read and gives one result word. The six channels are
// handled in six bit-serial lanes. A measurement with calibration done runs the serial
// subtract of the offset over T_W = max(16, 26 - OFFSET_FRAC_BITS) + 1 bits (19 at the
// defaults) before its result; raw or failed reads go straight to the result. A
// calibration attempt with a good read runs the serial accumulate over SUM_W = 16 +
// clog2(MAX_CALIB_SAMPLES) bits (28 at the defaults). The attempt that closes a run adds
// the 1 g product and six passes of the one shared serial divider.
// A new word is taken while the previous result still waits in the output register.
`default_nettype none

`include "assert_macros.svh"

module six_axis_bias_calibrator #(
  parameter int MAX_CALIB_SAMPLES = sabc_pkg::MAX_CALIB_SAMPLES_DEF,
  parameter int OFFSET_FRAC_BITS  = sabc_pkg::OFFSET_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire sabc_pkg::sample_t             sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output sabc_pkg::result_t                  result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sabc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sabc_pkg::DATA_W-1:0]   pwdata,
  output logic [sabc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int SAMPLE_W = sabc_pkg::SAMPLE_W;
  localparam int CH_N = sabc_pkg::CH_N;
  localparam int OFF_W = sabc_pkg::OFF_W;
  localparam int CNT_W = $clog2(MAX_CALIB_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_CALIB_SAMPLES);
  localparam int PROD_W = sabc_pkg::ONE_G_W + CNT_W;
  localparam int NUM_W = ((SUM_W > PROD_W + 1) ? SUM_W : PROD_W + 1) + 1;
  localparam int OQ_W = OFF_W - OFFSET_FRAC_BITS;
  localparam int T_W = ((SAMPLE_W > OQ_W) ? SAMPLE_W : OQ_W) + 1;
  localparam int SER_W = (SUM_W > T_W) ? SUM_W : T_W;
  localparam int SCNT_W = $clog2(SER_W);
  localparam int CH_W = $clog2(CH_N);

  localparam logic [OFF_W-1:0] FRAC_MASK = OFF_W'((1 << OFFSET_FRAC_BITS) - 1);
  localparam logic signed [T_W-1:0] T_HI = T_W'(sabc_pkg::SAT_MAX);
  localparam logic signed [T_W-1:0] T_LO = T_W'(sabc_pkg::SAT_MIN);

  sabc_pkg::state_t state, state_next;

  logic [sabc_pkg::COUNT_CFG_W-1:0] calib_sample_count;
  logic [sabc_pkg::ONE_G_W-1:0]     accel_one_g;

  logic [CNT_W-1:0] attempt_count;
  logic [CNT_W-1:0] valid_count;
  logic             calibrated;

  logic [CH_N-1:0][SUM_W-1:0]    sums;
  logic [CH_N-1:0][OFF_W-1:0]    offsets;
  logic [CH_N-1:0][SAMPLE_W-1:0] s_sh;
  logic [CH_N-1:0][T_W-1:0]      oq_sh;
  logic [CH_N-1:0][T_W-1:0]      t_sh;
  logic [CH_N-1:0][T_W-1:0]      u_sh;
  logic [CH_N-1:0]               carry;
  logic [CH_N-1:0]               brw_t;
  logic [CH_N-1:0]               brw_u;
  logic [SCNT_W-1:0]             bcnt;
  logic [CH_W-1:0]               ch;
  logic [PROD_W-1:0]             prod;
  logic signed [NUM_W-1:0]       num_r;

  sabc_pkg::status_t             pend_status;
  logic [CH_N-1:0][SAMPLE_W-1:0] pend_data;
  sabc_pkg::status_t             res_status;
  logic [CH_N-1:0][SAMPLE_W-1:0] res_data;

  logic [CH_N-1:0][SAMPLE_W-1:0] sample_lane;
  logic [CH_N-1:0]               acc_bit;
  logic [CH_N-1:0]               acc_cy;
  logic [CH_N-1:0]               t_bit;
  logic [CH_N-1:0]               t_brw;
  logic [CH_N-1:0]               u_bit;
  logic [CH_N-1:0]               u_brw;
  logic [CH_N-1:0][T_W-1:0]      oq_init;
  logic [CH_N-1:0][SAMPLE_W-1:0] corr;

  logic                          accept;
  logic                          out_free;
  logic                          cfg_wr;
  sabc_pkg::reg_idx_t            reg_idx;
  logic [CNT_W-1:0]              run_len;
  logic                          run_end;
  logic                          div_start;
  logic                          div_done;
  logic signed [OFF_W-1:0]       div_quo;
  logic signed [NUM_W-1:0]       sum_sel;

  sabc_div #(
    .NUM_W     (NUM_W),
    .CNT_W     (CNT_W),
    .FRAC_BITS (OFFSET_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (valid_count),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign pready = 1'b1;

  always_comb begin
    accept   = sample_valid & ~sample_stall;
    out_free = ~result_valid | ~result_stall;
    cfg_wr   = psel & penable & pwrite & pready;
    reg_idx  = sabc_pkg::reg_idx_t'(paddr[2]);
    case (reg_idx)
      sabc_pkg::REG_CALIB_SAMPLE_COUNT: prdata = sabc_pkg::DATA_W'(calib_sample_count);
      sabc_pkg::REG_ACCEL_ONE_G:        prdata = sabc_pkg::DATA_W'(accel_one_g);
      default:                          prdata = '0;
    endcase
  end

  always_comb begin
    if (calib_sample_count == '0) begin
      run_len = CNT_W'(1);
    end else if (32'(calib_sample_count) > 32'(MAX_CALIB_SAMPLES)) begin
      run_len = CNT_W'(MAX_CALIB_SAMPLES);
    end else begin
      run_len = CNT_W'(calib_sample_count);
    end
    run_end = attempt_count >= run_len;
    sum_sel = NUM_W'($signed(sums[ch]));
  end

  always_comb begin
    sample_lane[0] = sample.accel_x;
    sample_lane[1] = sample.accel_y;
    sample_lane[2] = sample.accel_z;
    sample_lane[3] = sample.gyro_x;
    sample_lane[4] = sample.gyro_y;
    sample_lane[5] = sample.gyro_z;
    result.status      = res_status;
    result.out_accel_x = res_data[0];
    result.out_accel_y = res_data[1];
    result.out_accel_z = res_data[2];
    result.out_gyro_x  = res_data[3];
    result.out_gyro_y  = res_data[4];
    result.out_gyro_z  = res_data[5];
  end

  // per-lane serial add, serial subtract of t = s - oq and of t - 1, final select
  always_comb begin
    logic [T_W-1:0] pick;
    logic           frac;
    for (int i = 0; i < CH_N; i++) begin
      acc_bit[i] = sums[i][0] ^ s_sh[i][0] ^ carry[i];
      acc_cy[i]  = (sums[i][0] & s_sh[i][0]) | (sums[i][0] & carry[i]) |
                   (s_sh[i][0] & carry[i]);
      t_bit[i]   = s_sh[i][0] ^ oq_sh[i][0] ^ brw_t[i];
      t_brw[i]   = (~s_sh[i][0] & oq_sh[i][0]) | (~s_sh[i][0] & brw_t[i]) |
                   (oq_sh[i][0] & brw_t[i]);
      u_bit[i]   = s_sh[i][0] ^ oq_sh[i][0] ^ brw_u[i];
      u_brw[i]   = (~s_sh[i][0] & oq_sh[i][0]) | (~s_sh[i][0] & brw_u[i]) |
                   (oq_sh[i][0] & brw_u[i]);
      oq_init[i] = T_W'($signed(offsets[i]) >>> OFFSET_FRAC_BITS);
      frac = |(offsets[i] & FRAC_MASK);
      // a fractional offset pulls a positive difference one step toward zero
      pick = (frac && !t_sh[i][T_W-1] && (t_sh[i] != '0)) ? u_sh[i] : t_sh[i];
      if ($signed(pick) > T_HI) begin
        corr[i] = SAMPLE_W'(sabc_pkg::SAT_MAX);
      end else if ($signed(pick) < T_LO) begin
        corr[i] = SAMPLE_W'(sabc_pkg::SAT_MIN);
      end else begin
        corr[i] = pick[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sabc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = (state != sabc_pkg::ST_IDLE);
    div_start    = 1'b0;
    case (state)
      sabc_pkg::ST_IDLE: begin
        if (accept) begin
          if (sample.command == sabc_pkg::CMD_CALIB) begin
            state_next = sample.read_ok ? sabc_pkg::ST_ACCUM : sabc_pkg::ST_DECIDE;
          end else if (sample.read_ok && calibrated) begin
            state_next = sabc_pkg::ST_CORR;
          end else begin
            state_next = sabc_pkg::ST_DONE;
          end
        end
      end
      sabc_pkg::ST_ACCUM: begin
        if (bcnt == SCNT_W'(SUM_W - 1)) begin
          state_next = sabc_pkg::ST_DECIDE;
        end
      end
      sabc_pkg::ST_DECIDE: begin
        if (run_end && (valid_count != '0)) begin
          state_next = sabc_pkg::ST_MUL;
        end else begin
          state_next = sabc_pkg::ST_DONE;
        end
      end
      sabc_pkg::ST_MUL: begin
        state_next = sabc_pkg::ST_NUM;
      end
      sabc_pkg::ST_NUM: begin
        state_next = sabc_pkg::ST_START;
      end
      sabc_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = sabc_pkg::ST_WAIT;
      end
      sabc_pkg::ST_WAIT: begin
        if (div_done) begin
          state_next = (ch == CH_W'(CH_N - 1)) ? sabc_pkg::ST_DONE : sabc_pkg::ST_NUM;
        end
      end
      sabc_pkg::ST_CORR: begin
        if (bcnt == SCNT_W'(T_W - 1)) begin
          state_next = sabc_pkg::ST_CFIX;
        end
      end
      sabc_pkg::ST_CFIX: begin
        state_next = sabc_pkg::ST_DONE;
      end
      sabc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sabc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sabc_pkg::ST_IDLE;
      end
    endcase
  end

  // run state, flags, config and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_sample_count <= sabc_pkg::CALIB_COUNT_RST;
      accel_one_g        <= sabc_pkg::ONE_G_RST;
      attempt_count      <= '0;
      valid_count        <= '0;
      calibrated         <= 1'b0;
      sums               <= '0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          sabc_pkg::REG_CALIB_SAMPLE_COUNT:
            calib_sample_count <= pwdata[sabc_pkg::COUNT_CFG_W-1:0];
          sabc_pkg::REG_ACCEL_ONE_G:
            accel_one_g <= pwdata[sabc_pkg::ONE_G_W-1:0];
          default: begin
          end
        endcase
      end
      if ((state == sabc_pkg::ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        sabc_pkg::ST_IDLE: begin
          if (accept && (sample.command == sabc_pkg::CMD_CALIB)) begin
            attempt_count <= attempt_count + 1'b1;
            valid_count   <= valid_count + CNT_W'(sample.read_ok);
          end
        end
        sabc_pkg::ST_ACCUM: begin
          for (int i = 0; i < CH_N; i++) begin
            sums[i] <= {acc_bit[i], sums[i][SUM_W-1:1]};
          end
        end
        sabc_pkg::ST_DECIDE: begin
          if (run_end && (valid_count == '0)) begin
            attempt_count <= '0;
            sums          <= '0;
          end
        end
        sabc_pkg::ST_WAIT: begin
          if (div_done && (ch == CH_W'(CH_N - 1))) begin
            attempt_count <= '0;
            valid_count   <= '0;
            sums          <= '0;
            calibrated    <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // lane shift registers, offsets and result words
  always_ff @(posedge clk) begin
    case (state)
      sabc_pkg::ST_IDLE: begin
        if (accept) begin
          s_sh   <= sample_lane;
          oq_sh  <= oq_init;
          carry  <= '0;
          brw_t  <= '0;
          brw_u  <= '1;
          bcnt   <= '0;
          pend_status <= sample.read_ok ? sabc_pkg::STAT_RAW : sabc_pkg::STAT_READ_FAIL;
          pend_data   <= sample.read_ok ? sample_lane : '0;
        end
      end
      sabc_pkg::ST_ACCUM: begin
        for (int i = 0; i < CH_N; i++) begin
          s_sh[i] <= {s_sh[i][SAMPLE_W-1], s_sh[i][SAMPLE_W-1:1]};
        end
        carry <= acc_cy;
        bcnt  <= bcnt + 1'b1;
      end
      sabc_pkg::ST_DECIDE: begin
        pend_data   <= '0;
        pend_status <= run_end ? sabc_pkg::STAT_CAL_FAIL : sabc_pkg::STAT_CAL_ACCEPT;
        ch          <= '0;
      end
      sabc_pkg::ST_MUL: begin
        prod <= PROD_W'(accel_one_g) * PROD_W'(valid_count);
      end
      sabc_pkg::ST_NUM: begin
        num_r <= (ch == CH_W'(sabc_pkg::ACCEL_Z_IDX)) ? sum_sel - $signed(NUM_W'(prod))
                                                       : sum_sel;
      end
      sabc_pkg::ST_WAIT: begin
        if (div_done) begin
          offsets[ch] <= div_quo;
          ch          <= ch + 1'b1;
          pend_status <= sabc_pkg::STAT_CAL_DONE;
        end
      end
      sabc_pkg::ST_CORR: begin
        for (int i = 0; i < CH_N; i++) begin
          s_sh[i]  <= {s_sh[i][SAMPLE_W-1], s_sh[i][SAMPLE_W-1:1]};
          oq_sh[i] <= {oq_sh[i][T_W-1], oq_sh[i][T_W-1:1]};
          t_sh[i]  <= {t_bit[i], t_sh[i][T_W-1:1]};
          u_sh[i]  <= {u_bit[i], u_sh[i][T_W-1:1]};
        end
        brw_t <= t_brw;
        brw_u <= u_brw;
        bcnt  <= bcnt + 1'b1;
      end
      sabc_pkg::ST_CFIX: begin
        pend_status <= sabc_pkg::STAT_CORRECTED;
        pend_data   <= corr;
      end
      sabc_pkg::ST_DONE: begin
        if (out_free) begin
          res_status <= pend_status;
          res_data   <= pend_data;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_valid_le_attempt, valid_count <= attempt_count, "valid count above attempts")
  `ASSERT_IMPLIES(a_cal_hold, !$past(rst), !$fell(calibrated), "calibrated flag dropped")
  `ASSERT_IMPLIES(a_result_from_done, $rose(result_valid), $past(state) == sabc_pkg::ST_DONE, "result word raised outside done")
  `ASSERT_IMPLIES(a_div_done_wait, div_done, state == sabc_pkg::ST_WAIT, "divider finished while not waited on")

endmodule

`default_nettype wire
